[hdl/ppa_pkg.sv]
// ppa_pkg: shared widths, codes and control structs for the page pool allocator
// used by the channel interfaces, the bitmap, stack, multiplier and top level
`default_nettype none

package ppa_pkg;

   localparam int PAGE_LIMIT  = 256;  // page_index is 8 bits wide
   localparam int OPCODE_W    = 2;
   localparam int IDX_W       = 8;
   localparam int STATUS_W    = 2;
   localparam int OFFSET_W    = 24;
   localparam int COUNT_W     = 9;
   localparam int STRIDE_W    = 17;
   localparam int CSR_ADDR_W  = 8;
   localparam int CSR_DATA_W  = 17;
   localparam int SCAN_W      = 32;
   localparam int SCAN_POS_W  = 5;
   localparam int MUL_CNT_W   = $clog2(IDX_W);

   typedef enum logic [OPCODE_W-1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_LOCATE = 2'd2,
      OP_CLEAR  = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 2'd0,
      ST_NO_FREE      = 2'd1,
      ST_RANGE        = 2'd2,
      ST_ALREADY_FREE = 2'd3
   } status_type;

   localparam logic [CSR_ADDR_W-1:0] REG_PAGE_COUNT   = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_STRIDE_BYTES = 8'd1;

   localparam logic [COUNT_W-1:0]  PAGE_COUNT_RESET = 9'd256;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET     = 17'd64;

   typedef struct packed {
      logic             set_bit;
      logic             clr_bit;
      logic             wipe;
      logic [IDX_W-1:0] idx;
   } map_ctrl_type;

   typedef struct packed {
      logic                  hit;
      logic [SCAN_POS_W-1:0] pos;
   } scan_res_type;

endpackage

`default_nettype wire

[hdl/ppa_if.sv]
// ppa_if: valid/ready channel interfaces for requests, responses and csr writes
// depends on ppa_pkg for field widths
`default_nettype none

interface ppa_req_if;
   import ppa_pkg::*;
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [IDX_W-1:0]    page_index;
   modport source (output valid, output opcode, output page_index, input ready);
   modport sink   (input valid, input opcode, input page_index, output ready);
endinterface

interface ppa_rsp_if;
   import ppa_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    page_index_out;
   logic [OFFSET_W-1:0] byte_offset;
   logic [COUNT_W-1:0]  pages_in_use;
   logic [IDX_W-1:0]    highest_in_use;
   modport source (output valid, output status, output page_index_out, output byte_offset,
                   output pages_in_use, output highest_in_use, input ready);
   modport sink   (input valid, input status, input page_index_out, input byte_offset,
                   input pages_in_use, input highest_in_use, output ready);
endinterface

interface ppa_csr_if;
   import ppa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/ppa_stack.sv]
// ppa_stack: free-list memory, one write and one registered read per cycle
// depends on ppa_pkg for the page index width
`default_nettype none

module ppa_stack #(
   parameter int DEPTH = 256
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  wire logic [ppa_pkg::IDX_W-1:0]     wr_data,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
   output      logic [ppa_pkg::IDX_W-1:0]     rd_data
);
   import ppa_pkg::*;

   logic [IDX_W-1:0] mem [DEPTH];
   logic [IDX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/ppa_bitmap.sv]
// ppa_bitmap: occupancy bitmap with a 32-bit chunk search for the highest set bit
// depends on ppa_pkg for map_ctrl_type and scan_res_type
`default_nettype none

module ppa_bitmap #(
   parameter int CHUNKS = 8,
   localparam int CIDX_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ppa_pkg::map_ctrl_type      ctrl,
   output      logic                       occ_rd,
   input  wire logic [CIDX_W-1:0]          scan_chunk,
   output      ppa_pkg::scan_res_type      scan_res
);
   import ppa_pkg::*;

   localparam int MAP_W     = CHUNKS * SCAN_W;
   localparam int MAP_IDX_W = $clog2(MAP_W);

   logic [MAP_W-1:0]     occ_ff;
   logic [MAP_W-1:0]     occ_in;
   logic [MAP_IDX_W-1:0] bit_idx;
   logic [SCAN_W-1:0]    chunk_bits;

   assign bit_idx = ctrl.idx[MAP_IDX_W-1:0];
   assign occ_rd  = occ_ff[bit_idx];

   always_comb begin
      occ_in = occ_ff;
      if (ctrl.wipe) begin
         occ_in = '0;
      end else if (ctrl.set_bit) begin
         occ_in[bit_idx] = 1'b1;
      end else if (ctrl.clr_bit) begin
         occ_in[bit_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // priority search, last set bit wins so the result is the highest one
   assign chunk_bits = occ_ff[scan_chunk*SCAN_W +: SCAN_W];

   always_comb begin
      scan_res.hit = |chunk_bits;
      scan_res.pos = '0;
      for (int i = 0; i < SCAN_W; i++) begin
         if (chunk_bits[i]) begin
            scan_res.pos = SCAN_POS_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

[hdl/ppa_mul.sv]
// ppa_mul: shift-add multiplier, page index times stride, one index bit a cycle
// depends on ppa_pkg for widths
`default_nettype none

module ppa_mul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [ppa_pkg::IDX_W-1:0]     multiplier,
   input  wire logic [ppa_pkg::STRIDE_W-1:0]  multiplicand,
   output      logic                          done,
   output      logic [ppa_pkg::OFFSET_W-1:0]  product
);
   import ppa_pkg::*;

   logic                 busy_ff;
   logic                 busy_in;
   logic                 done_ff;
   logic                 done_in;
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic [MUL_CNT_W-1:0] cnt_in;
   logic [OFFSET_W-1:0]  acc_ff;
   logic [OFFSET_W-1:0]  acc_in;
   logic [OFFSET_W-1:0]  mcand_ff;
   logic [OFFSET_W-1:0]  mcand_in;
   logic [IDX_W-1:0]     mplier_ff;
   logic [IDX_W-1:0]     mplier_in;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         acc_in    = '0;
         mcand_in  = OFFSET_W'(multiplicand);
         mplier_in = multiplier;
      end else if (busy_ff) begin
         // product bits from bit 24 up drop out of the shifted multiplicand
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(IDX_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

[hdl/page_pool_allocator.sv]
// page_pool_allocator: one item at a time under a small sequencer.
// allocate pops the free stack or takes a fresh page, then sets its bitmap bit; free
// searches one 32-bit bitmap chunk per step (up to 8) when the top page goes; locate
// waits for the 8 shift-add steps of the multiplier. the result register frees the
// input side: the sequencer is idle again once the response is registered.
// synchronous reset: empty pool, page_count 256, stride 64, no response pending
`default_nettype none

module page_pool_allocator #(
   parameter int MAX_PAGES = 256
) (
   input wire logic clock,
   input wire logic reset,
   ppa_req_if.sink   req,
   ppa_rsp_if.source rsp,
   ppa_csr_if.sink   csr
);
   import ppa_pkg::*;

   localparam int POOL_DEPTH = (MAX_PAGES < PAGE_LIMIT) ? MAX_PAGES : PAGE_LIMIT;
   localparam int SA_W       = $clog2(POOL_DEPTH);
   localparam int SD_W       = $clog2(POOL_DEPTH + 1);
   localparam int CHUNKS     = (POOL_DEPTH + SCAN_W - 1) / SCAN_W;
   localparam int CIDX_W     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_ALLOC_SET,
      S_SCAN,
      S_MUL,
      S_FINISH
   } state_type;

   state_type            state_ff, state_in;
   opcode_type           op_ff, op_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [COUNT_W-1:0]   page_count_ff, page_count_in;
   logic [STRIDE_W-1:0]  stride_ff, stride_in;
   logic [SD_W-1:0]      depth_ff, depth_in;
   logic [SD_W-1:0]      fresh_ff, fresh_in;
   logic [SD_W-1:0]      in_use_ff, in_use_in;
   logic [IDX_W-1:0]     highest_ff, highest_in;
   logic                 from_stack_ff, from_stack_in;
   logic [IDX_W-1:0]     got_fresh_ff, got_fresh_in;
   logic [CIDX_W-1:0]    scan_chunk_ff, scan_chunk_in;
   status_type           res_status_ff, res_status_in;
   logic [IDX_W-1:0]     res_idx_ff, res_idx_in;
   logic [OFFSET_W-1:0]  res_offset_ff, res_offset_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]     rsp_idx_ff, rsp_idx_in;
   logic [OFFSET_W-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [SD_W-1:0]      rsp_pages_ff, rsp_pages_in;
   logic [IDX_W-1:0]     rsp_high_ff, rsp_high_in;

   logic [COUNT_W-1:0]   count_eff;
   logic                 idx_out_of_range;
   logic [IDX_W-1:0]     got;

   map_ctrl_type         map_ctrl;
   logic                 occ_rd;
   scan_res_type         scan_res;

   logic                 stk_wr_en;
   logic                 stk_rd_en;
   logic [SA_W-1:0]      stk_rd_addr;
   logic [IDX_W-1:0]     stk_rd_data;

   logic                 mul_start;
   logic                 mul_done;
   logic [OFFSET_W-1:0]  mul_product;

   ppa_bitmap #(.CHUNKS(CHUNKS)) u_bitmap (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (map_ctrl),
      .occ_rd     (occ_rd),
      .scan_chunk (scan_chunk_ff),
      .scan_res   (scan_res)
   );

   ppa_stack #(.DEPTH(POOL_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (depth_ff[SA_W-1:0]),
      .wr_data (idx_ff),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   ppa_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplier   (idx_ff),
      .multiplicand (stride_ff),
      .done         (mul_done),
      .product      (mul_product)
   );

   assign count_eff = (page_count_ff > COUNT_W'(POOL_DEPTH)) ? COUNT_W'(POOL_DEPTH)
                                                              : page_count_ff;
   assign idx_out_of_range = COUNT_W'(idx_ff) >= count_eff;
   assign got = from_stack_ff ? stk_rd_data : got_fresh_ff;
   assign stk_rd_addr = SA_W'(depth_ff - 1'b1);

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      page_count_in = page_count_ff;
      stride_in     = stride_ff;
      depth_in      = depth_ff;
      fresh_in      = fresh_ff;
      in_use_in     = in_use_ff;
      highest_in    = highest_ff;
      from_stack_in = from_stack_ff;
      got_fresh_in  = got_fresh_ff;
      scan_chunk_in = scan_chunk_ff;
      res_status_in = res_status_ff;
      res_idx_in    = res_idx_ff;
      res_offset_in = res_offset_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_pages_in  = rsp_pages_ff;
      rsp_high_in   = rsp_high_ff;
      map_ctrl      = '{set_bit: 1'b0, clr_bit: 1'b0, wipe: 1'b0, idx: idx_ff};
      stk_wr_en     = 1'b0;
      stk_rd_en     = 1'b0;
      mul_start     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in    = opcode_type'(req.opcode);
               idx_in   = req.page_index;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_status_in = ST_OK;
            res_idx_in    = idx_ff;
            res_offset_in = '0;
            state_in      = S_FINISH;
            case (op_ff)
               OP_ALLOC: begin
                  if (depth_ff != '0) begin
                     stk_rd_en     = 1'b1;
                     depth_in      = depth_ff - 1'b1;
                     from_stack_in = 1'b1;
                     state_in      = S_ALLOC_SET;
                  end else if (COUNT_W'(fresh_ff) < count_eff) begin
                     got_fresh_in  = IDX_W'(fresh_ff);
                     fresh_in      = fresh_ff + 1'b1;
                     from_stack_in = 1'b0;
                     state_in      = S_ALLOC_SET;
                  end else begin
                     res_status_in = ST_NO_FREE;
                  end
               end
               OP_FREE: begin
                  if (idx_out_of_range) begin
                     res_status_in = ST_RANGE;
                  end else if (!occ_rd) begin
                     res_status_in = ST_ALREADY_FREE;
                  end else begin
                     map_ctrl.clr_bit = 1'b1;
                     stk_wr_en        = 1'b1;
                     depth_in         = depth_ff + 1'b1;
                     in_use_in        = in_use_ff - 1'b1;
                     if (idx_ff == highest_ff) begin
                        // top page left: search downward from its chunk
                        highest_in = '0;
                        if (in_use_ff != SD_W'(1)) begin
                           scan_chunk_in = CIDX_W'(idx_ff >> SCAN_POS_W);
                           state_in      = S_SCAN;
                        end
                     end
                  end
               end
               OP_LOCATE: begin
                  if (idx_out_of_range) begin
                     res_status_in = ST_RANGE;
                  end else begin
                     mul_start = 1'b1;
                     state_in  = S_MUL;
                  end
               end
               OP_CLEAR: begin
                  map_ctrl.wipe = 1'b1;
                  depth_in      = '0;
                  fresh_in      = '0;
                  in_use_in     = '0;
                  highest_in    = '0;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_ALLOC_SET: begin
            map_ctrl.set_bit = 1'b1;
            map_ctrl.idx     = got;
            in_use_in        = in_use_ff + 1'b1;
            if (in_use_ff == '0 || got > highest_ff) begin
               highest_in = got;
            end
            res_idx_in = got;
            state_in   = S_FINISH;
         end
         S_SCAN: begin
            if (scan_res.hit) begin
               highest_in = IDX_W'({scan_chunk_ff, scan_res.pos});
               state_in   = S_FINISH;
            end else if (scan_chunk_ff == '0) begin
               state_in = S_FINISH;
            end else begin
               scan_chunk_in = scan_chunk_ff - 1'b1;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               res_offset_in = mul_product;
               state_in      = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_idx_in    = res_idx_ff;
               rsp_offset_in = res_offset_ff;
               rsp_pages_in  = in_use_ff;
               rsp_high_in   = highest_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register writes must arrive only while idle; the block itself does not enforce this
      if (csr.valid) begin
         if (csr.index == REG_PAGE_COUNT) begin
            page_count_in = csr.data[COUNT_W-1:0];
            map_ctrl.wipe = 1'b1;
            depth_in      = '0;
            fresh_in      = '0;
            in_use_in     = '0;
            highest_in    = '0;
         end else if (csr.index == REG_STRIDE_BYTES) begin
            stride_in = csr.data[STRIDE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         page_count_ff <= PAGE_COUNT_RESET;
         stride_ff     <= STRIDE_RESET;
         depth_ff      <= '0;
         fresh_ff      <= '0;
         in_use_ff     <= '0;
         highest_ff    <= '0;
         from_stack_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         page_count_ff <= page_count_in;
         stride_ff     <= stride_in;
         depth_ff      <= depth_in;
         fresh_ff      <= fresh_in;
         in_use_ff     <= in_use_in;
         highest_ff    <= highest_in;
         from_stack_ff <= from_stack_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      got_fresh_ff  <= got_fresh_in;
      scan_chunk_ff <= scan_chunk_in;
      res_status_ff <= res_status_in;
      res_idx_ff    <= res_idx_in;
      res_offset_ff <= res_offset_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_pages_ff  <= rsp_pages_in;
      rsp_high_ff   <= rsp_high_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_status_ff;
   assign rsp.page_index_out = rsp_idx_ff;
   assign rsp.byte_offset    = rsp_offset_ff;
   assign rsp.pages_in_use   = COUNT_W'(rsp_pages_ff);
   assign rsp.highest_in_use = rsp_high_ff;

endmodule

`default_nettype wire

[hdl/ppa_checker.sv]
// ppa_checker: port-level assertions for page_pool_allocator, bound to the top level
// depends on ppa_pkg for status codes
`default_nettype none

module ppa_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [ppa_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic [ppa_pkg::IDX_W-1:0]     rsp_page_index_out,
   input wire logic [ppa_pkg::OFFSET_W-1:0]  rsp_byte_offset,
   input wire logic [ppa_pkg::COUNT_W-1:0]   rsp_pages_in_use,
   input wire logic [ppa_pkg::IDX_W-1:0]     rsp_highest_in_use
);
   import ppa_pkg::*;

   // a stalled item keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_page_index_out) && $stable(rsp_byte_offset)
         && $stable(rsp_pages_in_use) && $stable(rsp_highest_in_use))
      else $error("response changed while stalled");

   // an empty pool reports highest index zero
   a_empty_highest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pages_in_use == '0 |-> rsp_highest_in_use == '0)
      else $error("highest index nonzero on empty pool");

   // a nonzero offset only comes with status ok
   a_offset_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_offset != '0 |-> rsp_status == ST_OK)
      else $error("offset on failed item");

   // reset drops any pending response
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind page_pool_allocator ppa_checker u_ppa_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_status         (rsp.status),
   .rsp_page_index_out (rsp.page_index_out),
   .rsp_byte_offset    (rsp.byte_offset),
   .rsp_pages_in_use   (rsp.pages_in_use),
   .rsp_highest_in_use (rsp.highest_in_use)
);

`default_nettype wire
